// ===== rtl/pressure_sensor_compensation_top_defines.svh =====
// Assertion macros for the pressure sensor compensation block.
`ifndef PRESSURE_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error("%m: check failed");
// Next-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error("%m: check failed");
`else
`define PSC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/psc_pkg.sv =====
// Shared types and constants for the pressure sensor compensation block.
`default_nettype none
package psc_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FOUR  = 2'd3;

  typedef struct packed {
    logic [15:0] raw_pressure;
    logic [15:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [18:0] pressure;
    logic signed [15:0] temp_first_order;
    logic signed [15:0] temp_second_order;
  } out_t;

  // Coefficient terms, already offset where the formulas need it.
  typedef struct packed {
    logic        [15:0] ut1;    // 8*c5 + 10000
    logic        [7:0]  tk;     // c6 + 100
    logic signed [9:0]  ok;     // c4 - 250
    logic        [10:0] sk;     // c3 + 200
    logic        [12:0] c2;
    logic        [11:0] c1h;    // c1 >> 1
  } coef_t;

  // Values handed from the front stages to the back stages.
  typedef struct packed {
    logic signed [16:0] sens;
    logic signed [17:0] diff;   // D1 - OFF
    logic signed [17:0] dt2;
    logic signed [15:0] temp;
  } mid_t;

endpackage
`default_nettype wire

// ===== rtl/psc_cal_regs.sv =====
// Calibration word registers and coefficient unpacking.
`default_nettype none
module psc_cal_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data,
  output psc_pkg::coef_t                 coef
);
  import psc_pkg::*;

  logic [15:0] word_one_r, word_two_r, word_three_r, word_four_r;
  logic [12:0] c1;
  logic [12:0] c2;
  logic [9:0]  c3;
  logic [8:0]  c4;
  logic [11:0] c5;
  logic [6:0]  c6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_one_r   <= '0;
      word_two_r   <= '0;
      word_three_r <= '0;
      word_four_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CAL_ONE:   word_one_r   <= cfg_data;
        CFG_CAL_TWO:   word_two_r   <= cfg_data;
        CFG_CAL_THREE: word_three_r <= cfg_data;
        CFG_CAL_FOUR:  word_four_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    c1 = word_one_r[15:3];
    c2 = {word_one_r[2:0], word_two_r[15:6]};
    c3 = word_three_r[15:6];
    c4 = word_four_r[15:7];
    c5 = {word_two_r[5:0], word_three_r[5:0]};
    c6 = word_four_r[6:0];

    coef.ut1 = {1'b0, c5, 3'b000} + 16'd10000;
    coef.tk  = {1'b0, c6} + 8'd100;
    coef.ok  = $signed({1'b0, c4}) - 10'sd250;
    coef.sk  = {1'b0, c3} + 11'd200;
    coef.c2  = c2;
    coef.c1h = c1[12:1];
  end

endmodule
`default_nettype wire

// ===== rtl/psc_front.sv =====
// Front stages: temperature delta, coefficient products, offset, sensitivity, temperature and second-order delta sums.
`default_nettype none
module psc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  psc_pkg::coef_t  coef,
  input  logic            in_valid,
  output logic            in_ready,
  input  psc_pkg::in_t    in_data,
  output logic            mid_valid,
  input  logic            mid_ready,
  output psc_pkg::mid_t   mid_data
);
  import psc_pkg::*;

  logic en1, en2, en3;

  // stage 1
  logic               v1_r;
  logic signed [16:0] dt1_r, dt1_nxt;
  logic [15:0]        d1_1_r;

  // stage 2
  logic               v2_r;
  logic signed [25:0] tmul_r, tmul_nxt;
  logic signed [26:0] omul_r, omul_nxt;
  logic signed [28:0] smul_r, smul_nxt;
  logic signed [19:0] qq_r, qq_nxt;
  logic signed [9:0]  q;
  logic signed [16:0] dt2s_r;
  logic [15:0]        d1_2_r;

  // stage 3
  logic               v3_r;
  mid_t               mid_r, mid_nxt;
  logic signed [16:0] off;

  assign en3      = !v3_r || mid_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign dt1_nxt = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, coef.ut1});

  always_comb begin
    q        = $signed(dt1_r[16:7]);
    tmul_nxt = 26'(dt1_r) * 26'($signed({1'b0, coef.tk}));
    omul_nxt = 27'(dt1_r) * 27'($signed(coef.ok));
    smul_nxt = 29'(dt1_r) * 29'($signed({1'b0, coef.sk}));
    qq_nxt   = 20'(q) * 20'(q);
  end

  always_comb begin
    off = 17'sd10000 + $signed({4'b0000, coef.c2}) + 17'($signed(omul_r[26:12]));
    mid_nxt.temp = 16'sd200 + 16'($signed(tmul_r[25:11]));
    mid_nxt.sens = 17'sd3000 + $signed({5'b00000, coef.c1h}) + 17'($signed(smul_r[28:13]));
    mid_nxt.diff = $signed({2'b00, d1_2_r}) - 18'(off);
    mid_nxt.dt2  = 18'(dt2s_r) - 18'($signed(qq_r[19:3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dt1_r  <= dt1_nxt;
      d1_1_r <= in_data.raw_pressure;
    end
    if (en2) begin
      tmul_r <= tmul_nxt;
      omul_r <= omul_nxt;
      smul_r <= smul_nxt;
      qq_r   <= qq_nxt;
      dt2s_r <= dt1_r;
      d1_2_r <= d1_1_r;
    end
    if (en3) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = v3_r;
  assign mid_data  = mid_r;

endmodule
`default_nettype wire

// ===== rtl/psc_back.sv =====
// Back stages: pressure and second-order temperature products, result register.
`default_nettype none
module psc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  psc_pkg::coef_t  coef,
  input  logic            mid_valid,
  output logic            mid_ready,
  input  psc_pkg::mid_t   mid_data,
  output logic            out_valid,
  input  logic            out_ready,
  output psc_pkg::out_t   out_data
);
  import psc_pkg::*;

  logic en4, en5;

  // stage 4
  logic               v4_r;
  logic signed [34:0] pmul_r, pmul_nxt;
  logic signed [26:0] t2mul_r, t2mul_nxt;
  logic signed [15:0] temp4_r;

  // stage 5 (result register)
  logic               v5_r;
  out_t               out_r, out_nxt;

  assign en5       = !v5_r || out_ready;
  assign en4       = !v4_r || en5;
  assign mid_ready = en4;

  always_comb begin
    pmul_nxt  = 35'($signed(mid_data.sens)) * 35'($signed(mid_data.diff));
    t2mul_nxt = 27'($signed(mid_data.dt2)) * 27'($signed({1'b0, coef.tk}));
  end

  always_comb begin
    out_nxt.pressure          = $signed(pmul_r[30:12]) + 19'sd1000;
    out_nxt.temp_first_order  = temp4_r;
    out_nxt.temp_second_order = $signed(t2mul_r[26:11]) + 16'sd200;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= mid_valid;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pmul_r  <= pmul_nxt;
      t2mul_r <= t2mul_nxt;
      temp4_r <= $signed(mid_data.temp);
    end
    if (en5) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/pressure_sensor_compensation_top.sv =====
// Top level of the barometric sensor calibration compensation pipeline.
`default_nettype none
`include "pressure_sensor_compensation_top_defines.svh"
// Takes one raw pressure / raw temperature transaction per clock while in_ready is high and returns
// compensated pressure, first-order temperature and second-order temperature
// (both in tenths of a degree), one result per input, in order.
// Five register stages: temperature delta; coefficient products; offset,
// sensitivity and second-order delta sums; pressure and second-order products;
// output register. Each stage holds a valid bit and loads whenever it is empty
// or the stage after it moves, so bubbles collapse and a full pipeline keeps
// streaming at one transaction per cycle as long as out_ready stays high.
// in_ready is combinational from out_ready through that enable chain.
// The four calibration words reset to zero and are written through the cfg
// channel (always ready); write them only while the pipeline is empty.
module pressure_sensor_compensation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  psc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output psc_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import psc_pkg::*;

  coef_t coef;
  logic  mid_valid;
  logic  mid_ready;
  mid_t  mid_data;

  assign cfg_ready = 1'b1;

  // calibration words -> unpacked, offset coefficient terms
  psc_cal_regs u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // stages 1-3
  psc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_data  (mid_data)
  );

  // stages 4-5
  psc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_data  (mid_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A sink that takes results never backs up the input.
  `PSC_ASSERT_NOW(a_ready_follows_sink, clk, rst_n, out_ready, in_ready)
  // An empty result register frees every stage.
  `PSC_ASSERT_NOW(a_ready_when_out_empty, clk, rst_n, !out_valid, in_ready)
  // With the sink held ready, an accepted transaction reaches the output register.
  `PSC_ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule
`default_nettype wire
